// ===== rtl/core/rvex_pkg.sv =====
// Shared definitions of the RV32I execute unit: opcodes, funct3 codes,
// result status codes and the default data memory size. No dependencies.
`timescale 1ns / 1ps

package rvex_pkg;

	localparam int unsigned MEM_BYTES_DEF = 131072;

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// ALU funct3 codes.
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// Load and store funct3 codes.
	localparam logic [2:0] F3_B  = 3'd0;
	localparam logic [2:0] F3_H  = 3'd1;
	localparam logic [2:0] F3_W  = 3'd2;
	localparam logic [2:0] F3_BU = 3'd4;
	localparam logic [2:0] F3_HU = 3'd5;

	// Branch funct3 codes.
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic OP_EXEC    = 1'b0;
	localparam logic OP_PRELOAD = 1'b1;

	typedef enum logic [1:0] {
		ST_EXEC    = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_PRELOAD = 2'd2
	} status_t;

endpackage

// ===== rtl/core/rvex_if.sv =====
// Valid/ready channel interfaces of the RV32I execute unit: the request
// channel (instructions and preloads) and the result channel. No dependencies.
`timescale 1ns / 1ps

interface rvex_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] instr;
	logic [16:0] preload_addr;
	logic [7:0]  preload_byte;

	modport source (output valid, op, instr, preload_addr, preload_byte, input ready);
	modport sink   (input valid, op, instr, preload_addr, preload_byte, output ready);
endinterface

interface rvex_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] inst_addr;
	logic [1:0]  status;
	logic        reg_write;
	logic [4:0]  dest_reg;
	logic [31:0] dest_value;
	logic [31:0] next_pc;

	modport source (output valid, inst_addr, status, reg_write, dest_reg, dest_value,
		next_pc, input ready);
	modport sink   (input valid, inst_addr, status, reg_write, dest_reg, dest_value,
		next_pc, output ready);
endinterface

// ===== rtl/core/rv32i_execute_unit_core.sv =====
// Top level of the RV32I execute unit: register file and data memory in RAMs,
// decode, execute and load alignment. Depends on rvex_pkg, rvex_if, rvex_ram, rvex_alu.
`timescale 1ns / 1ps

// Executes one RV32I instruction (ALU register and immediate forms, loads,
// stores, branches, JAL) or preloads one data memory byte per request beat,
// and returns exactly one result beat per request, in order. The register
// file sits in two 32x32 RAM copies (one per source operand) with a valid bit
// per entry so that it reads zero after reset; the data memory is four byte
// lane RAMs of MEM_BYTES/4 entries, so a misaligned access of up to four bytes
// touches each lane once. MEM_BYTES must be a power of two; addresses wrap
// within it. Data memory has no reset: a load of a byte never written returns
// an arbitrary value. Timing: the register file is read when a request is
// accepted and the instruction executes in the next cycle, so ALU, store,
// branch, JAL and preload items sustain one beat per cycle while the result
// channel takes beats. A load goes on to stage 2 for its data memory read, and
// the item after it waits in stage 1 until the load has left stage 2.
// The result sits in an output register, so a new request is accepted while a
// finished result still waits for the sink.
module rv32i_execute_unit_core #(
	parameter int unsigned MEM_BYTES = rvex_pkg::MEM_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rvex_req_if.sink  req,
	rvex_rsp_if.source rsp
);
	import rvex_pkg::*;

	localparam int unsigned AW     = $clog2(MEM_BYTES);
	localparam int unsigned ROWS   = MEM_BYTES / 4;
	localparam int unsigned ROW_AW = AW - 2;

	// Handshake and pipeline control.
	logic accept;
	logic s1_adv;
	logic s2_adv;
	logic out_free;
	logic out_push;

	// Stage 1: the accepted item with its operands arriving from the register file.
	logic        valid_s1;
	logic        first_s1;
	logic        op_s1;
	logic [31:0] instr_s1;
	logic [16:0] paddr_s1;
	logic [7:0]  pbyte_s1;
	logic        va_s1;
	logic        vb_s1;
	logic [31:0] ahold_s1;
	logic [31:0] bhold_s1;

	// Stage 2: a load waiting for its data memory read.
	logic        valid_s2;
	logic        wr_s2;
	logic [4:0]  rd_s2;
	logic [2:0]  f3_s2;
	logic [1:0]  off_s2;
	logic [31:0] pc_s2;

	// Architectural state outside the RAMs.
	logic [31:0] pc_q;
	logic [31:0] rf_valid_q;

	// Last register file write, seen for one cycle so that reads can forward it.
	logic        wb_v_q;
	logic [4:0]  wb_rd_q;
	logic [31:0] wb_val_q;

	// Output register.
	logic        out_valid_q;
	logic [31:0] out_addr_q;
	status_t     out_status_q;
	logic        out_wr_q;
	logic [4:0]  out_rd_q;
	logic [31:0] out_val_q;
	logic [31:0] out_next_q;

	// Register file ports.
	logic        rf_we;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;
	logic [31:0] rf_a_rdata;
	logic [31:0] rf_b_rdata;

	// Decode and execute.
	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [6:0]  f7;
	logic [31:0] immi;
	logic [31:0] imms;
	logic [31:0] immb;
	logic [31:0] immj;
	logic [31:0] a_eff;
	logic [31:0] b_eff;
	logic [31:0] alu_b;
	logic        alu_alt;
	logic [2:0]  alu_f3;
	logic [31:0] alu_y;
	logic [31:0] mem_addr32;
	logic [AW-1:0] mem_addr;
	logic [31:0] pc_plus4;
	logic [31:0] target;
	logic        legal;
	logic        wr_en;
	logic        is_load;
	logic        is_store;
	logic        taken;
	logic        use_jal;
	logic [31:0] val;
	logic [31:0] next_pc;
	status_t     status;
	logic [2:0]  store_n;

	// Byte lanes of the data memory.
	logic              lane_we    [4];
	logic [ROW_AW-1:0] lane_waddr [4];
	logic [7:0]        lane_wdata [4];
	logic              lane_re;
	logic [ROW_AW-1:0] lane_raddr [4];
	logic [7:0]        lane_rdata [4];

	// Load alignment.
	logic [7:0]  ld_byte [4];
	logic [31:0] ld_val;

	assign out_free = !out_valid_q || rsp.ready;
	assign s1_adv   = valid_s1 && !valid_s2 && (is_load || out_free);
	assign s2_adv   = valid_s2 && out_free;
	assign req.ready = !valid_s1 || s1_adv;
	assign accept   = req.valid && req.ready;
	assign out_push = (s1_adv && !is_load) || s2_adv;

	// Field extraction.
	assign opc = instr_s1[6:0];
	assign rd  = instr_s1[11:7];
	assign f3  = instr_s1[14:12];
	assign rs1 = instr_s1[19:15];
	assign rs2 = instr_s1[24:20];
	assign f7  = instr_s1[31:25];
	assign immi = {{20{instr_s1[31]}}, instr_s1[31:20]};
	assign imms = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
	assign immb = {{19{instr_s1[31]}}, instr_s1[31], instr_s1[7], instr_s1[30:25],
		instr_s1[11:8], 1'b0};
	assign immj = {{11{instr_s1[31]}}, instr_s1[31], instr_s1[19:12], instr_s1[20],
		instr_s1[30:21], 1'b0};

	// Operands: a write that lands while the item sits in stage 1 overrides the
	// RAM data, which was read before that write. Invalid entries read zero.
	always_comb begin
		if (wb_v_q && wb_rd_q == rs1) begin
			a_eff = wb_val_q;
		end else if (first_s1) begin
			a_eff = va_s1 ? rf_a_rdata : 32'd0;
		end else begin
			a_eff = ahold_s1;
		end
		if (wb_v_q && wb_rd_q == rs2) begin
			b_eff = wb_val_q;
		end else if (first_s1) begin
			b_eff = vb_s1 ? rf_b_rdata : 32'd0;
		end else begin
			b_eff = bhold_s1;
		end
	end

	// Immediate shifts take the shift amount from the rs2 field.
	assign alu_b   = (opc == OPC_OP) ? b_eff :
		((f3 == F3_SLL || f3 == F3_SRL) ? {27'd0, rs2} : immi);
	assign alu_alt = (f7 == F7_ALT) && (f3 == F3_SRL || (opc == OPC_OP && f3 == F3_ADD));
	assign alu_f3  = f3;

	rvex_alu u_alu (
		.f3  (alu_f3),
		.alt (alu_alt),
		.a   (a_eff),
		.b   (alu_b),
		.y   (alu_y)
	);

	assign mem_addr32 = a_eff + ((opc == OPC_STORE) ? imms : immi);
	assign mem_addr   = mem_addr32[AW-1:0];
	assign pc_plus4   = pc_q + 32'd4;
	assign use_jal    = (opc == OPC_JAL);
	assign target     = pc_q + (use_jal ? immj : immb);

	// Decode: legality, write enable, result value and next pc.
	always_comb begin
		legal    = 1'b0;
		wr_en    = 1'b0;
		is_load  = 1'b0;
		is_store = 1'b0;
		taken    = 1'b0;
		val      = alu_y;
		store_n  = 3'd4;
		unique case (opc)
			OPC_OP: begin
				legal = (f7 == F7_BASE) || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL));
				wr_en = 1'b1;
			end
			OPC_OPIMM: begin
				if (f3 == F3_SLL) begin
					legal = (f7 == F7_BASE);
				end else if (f3 == F3_SRL) begin
					legal = (f7 == F7_BASE) || (f7 == F7_ALT);
				end else begin
					legal = 1'b1;
				end
				wr_en = 1'b1;
			end
			OPC_LOAD: begin
				legal   = (f3 == F3_B || f3 == F3_H || f3 == F3_W || f3 == F3_BU
					|| f3 == F3_HU);
				is_load = legal;
				wr_en   = 1'b1;
			end
			OPC_STORE: begin
				legal    = (f3 == F3_B || f3 == F3_H || f3 == F3_W);
				is_store = legal;
				store_n  = (f3 == F3_B) ? 3'd1 : ((f3 == F3_H) ? 3'd2 : 3'd4);
			end
			OPC_BRANCH: begin
				legal = (f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BLT || f3 == F3_BGE
					|| f3 == F3_BLTU || f3 == F3_BGEU);
				unique case (f3)
					F3_BEQ:  taken = (a_eff == b_eff);
					F3_BNE:  taken = (a_eff != b_eff);
					F3_BLT:  taken = ($signed(a_eff) < $signed(b_eff));
					F3_BGE:  taken = ($signed(a_eff) >= $signed(b_eff));
					F3_BLTU: taken = (a_eff < b_eff);
					F3_BGEU: taken = (a_eff >= b_eff);
					default: taken = 1'b0;
				endcase
			end
			OPC_JAL: begin
				legal = 1'b1;
				wr_en = 1'b1;
				taken = 1'b1;
				val   = pc_plus4;
			end
			default: begin
				legal = 1'b0;
			end
		endcase
		// Preloads never reach the instruction paths.
		if (op_s1 == OP_PRELOAD) begin
			is_load  = 1'b0;
			is_store = 1'b0;
		end
	end

	always_comb begin
		if (op_s1 == OP_PRELOAD) begin
			status  = ST_PRELOAD;
			next_pc = pc_q;
		end else if (!legal) begin
			status  = ST_UNKNOWN;
			next_pc = pc_plus4;
		end else begin
			status  = ST_EXEC;
			next_pc = taken ? target : pc_plus4;
		end
	end

	// Byte lane addressing: lane l holds byte index (l - addr[1:0]) mod 4 of
	// the access, which lives at row (addr + index) / 4.
	always_comb begin
		logic [1:0]  bidx;
		logic [AW-1:0] baddr;
		logic [AW-1:0] paddr;
		paddr = AW'(32'(paddr_s1));
		for (int l = 0; l < 4; l++) begin
			bidx  = 2'(l) - mem_addr[1:0];
			baddr = mem_addr + AW'(bidx);
			lane_raddr[l] = baddr[AW-1:2];
			if (op_s1 == OP_PRELOAD) begin
				lane_we[l]    = s1_adv && (paddr[1:0] == 2'(l));
				lane_waddr[l] = paddr[AW-1:2];
				lane_wdata[l] = pbyte_s1;
			end else begin
				lane_we[l]    = s1_adv && is_store && ({1'b0, bidx} < store_n);
				lane_waddr[l] = baddr[AW-1:2];
				lane_wdata[l] = 8'(b_eff >> {bidx, 3'b000});
			end
		end
	end
	assign lane_re = s1_adv && is_load;

	for (genvar g = 0; g < 4; g++) begin : g_lane
		rvex_ram #(
			.WIDTH (8),
			.DEPTH (ROWS)
		) u_dmem (
			.clk   (clk),
			.we    (lane_we[g]),
			.waddr (lane_waddr[g]),
			.wdata (lane_wdata[g]),
			.re    (lane_re),
			.raddr (lane_raddr[g]),
			.rdata (lane_rdata[g])
		);
	end

	// Load alignment in stage 2.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ld_byte[i] = lane_rdata[2'(off_s2 + 2'(i))];
		end
		unique case (f3_s2)
			F3_B:    ld_val = {{24{ld_byte[0][7]}}, ld_byte[0]};
			F3_H:    ld_val = {{16{ld_byte[1][7]}}, ld_byte[1], ld_byte[0]};
			F3_BU:   ld_val = {24'd0, ld_byte[0]};
			F3_HU:   ld_val = {16'd0, ld_byte[1], ld_byte[0]};
			default: ld_val = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
		endcase
	end

	// Register file: two RAM copies share the write port.
	always_comb begin
		if (s2_adv) begin
			rf_we = wr_s2;
			rf_wa = rd_s2;
			rf_wd = ld_val;
		end else begin
			rf_we = s1_adv && !is_load && (op_s1 == OP_EXEC) && legal && wr_en
				&& (rd != 5'd0);
			rf_wa = rd;
			rf_wd = val;
		end
	end

	rvex_ram #(
		.WIDTH (32),
		.DEPTH (32)
	) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_wa),
		.wdata (rf_wd),
		.re    (accept),
		.raddr (req.instr[19:15]),
		.rdata (rf_a_rdata)
	);

	rvex_ram #(
		.WIDTH (32),
		.DEPTH (32)
	) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_wa),
		.wdata (rf_wd),
		.re    (accept),
		.raddr (req.instr[24:20]),
		.rdata (rf_b_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			first_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			pc_q        <= 32'd0;
			rf_valid_q  <= 32'd0;
			wb_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			first_s1 <= accept;
			if (s1_adv && is_load) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s1_adv) begin
				pc_q <= next_pc;
			end
			if (rf_we) begin
				rf_valid_q[rf_wa] <= 1'b1;
			end
			wb_v_q <= rf_we;
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= req.op;
			instr_s1 <= req.instr;
			paddr_s1 <= req.preload_addr;
			pbyte_s1 <= req.preload_byte;
			va_s1    <= rf_valid_q[req.instr[19:15]];
			vb_s1    <= rf_valid_q[req.instr[24:20]];
		end
		if (valid_s1) begin
			ahold_s1 <= a_eff;
			bhold_s1 <= b_eff;
		end
		if (s1_adv && is_load) begin
			wr_s2  <= (rd != 5'd0);
			rd_s2  <= rd;
			f3_s2  <= f3;
			off_s2 <= mem_addr[1:0];
			pc_s2  <= pc_q;
		end
		if (rf_we) begin
			wb_rd_q  <= rf_wa;
			wb_val_q <= rf_wd;
		end
		if (s2_adv) begin
			out_addr_q   <= pc_s2;
			out_status_q <= ST_EXEC;
			out_wr_q     <= wr_s2;
			out_rd_q     <= wr_s2 ? rd_s2 : 5'd0;
			out_val_q    <= wr_s2 ? ld_val : 32'd0;
			out_next_q   <= pc_s2 + 32'd4;
		end else if (out_push) begin
			out_addr_q   <= pc_q;
			out_status_q <= status;
			out_wr_q     <= rf_we;
			out_rd_q     <= rf_we ? rd : 5'd0;
			out_val_q    <= rf_we ? val : 32'd0;
			out_next_q   <= next_pc;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.inst_addr  = out_addr_q;
	assign rsp.status     = out_status_q;
	assign rsp.reg_write  = out_wr_q;
	assign rsp.dest_reg   = out_rd_q;
	assign rsp.dest_value = out_val_q;
	assign rsp.next_pc    = out_next_q;
endmodule

// ===== rtl/core/rvex_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rvex_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read data holds until the next read enable.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/core/rvex_alu.sv =====
// Integer ALU of the RV32I execute unit, shared by register and immediate forms.
// Depends on rvex_pkg.
`timescale 1ns / 1ps

module rvex_alu (
	input  logic [2:0]  f3,
	input  logic        alt,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import rvex_pkg::*;

	always_comb begin
		unique case (f3)
			F3_ADD:  y = alt ? (a - b) : (a + b);
			F3_SLL:  y = a << b[4:0];
			F3_SLT:  y = {31'd0, ($signed(a) < $signed(b))};
			F3_SLTU: y = {31'd0, (a < b)};
			F3_XOR:  y = a ^ b;
			F3_SRL:  y = alt ? 32'($signed(a) >>> b[4:0]) : (a >> b[4:0]);
			F3_OR:   y = a | b;
			F3_AND:  y = a & b;
			default: y = a & b;
		endcase
	end
endmodule

// ===== sim/rv32i_execute_unit_core_tb.sv =====
// Self-checking testbench of the RV32I execute unit: directed and random
// instruction and preload beats, checked against a behavioral predictor.
// Depends on rvex_pkg, rvex_if and rv32i_execute_unit_core.
`timescale 1ns / 1ps

module rv32i_execute_unit_core_tb;
	import rvex_pkg::*;

	localparam int unsigned MEM_SIZE = MEM_BYTES_DEF;
	localparam int NUM_RANDOM = 1200;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [31:0] inst_addr;
		status_t     status;
		logic        reg_write;
		logic [4:0]  dest_reg;
		logic [31:0] dest_value;
		logic [31:0] next_pc;
	} exec_result_t;

	// Architectural copy of the core: it executes every accepted beat in order
	// and keeps the results the core must return.
	class exec_scoreboard;
		logic [31:0]  regs[32];
		logic [31:0]  pc;
		logic [7:0]   mem[MEM_SIZE];
		bit           written[MEM_SIZE];
		exec_result_t pending[$];
		int           errors;
		int           checked;

		function new();
			foreach (regs[i]) regs[i] = '0;
			pc = '0;
			errors = 0;
			checked = 0;
		endfunction

		function logic [31:0] xreg(logic [4:0] idx);
			return (idx == 5'd0) ? 32'd0 : regs[idx];
		endfunction

		function logic [7:0] rd_byte(logic [31:0] addr);
			return mem[addr % MEM_SIZE];
		endfunction

		function void wr_byte(logic [31:0] addr, logic [7:0] value);
			mem[addr % MEM_SIZE] = value;
			written[addr % MEM_SIZE] = 1'b1;
		endfunction

		function logic [31:0] alu(logic [2:0] f3, bit alt, logic [31:0] a, logic [31:0] b);
			case (f3)
				F3_ADD:  return alt ? a - b : a + b;
				F3_SLL:  return a << b[4:0];
				F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
				F3_XOR:  return a ^ b;
				F3_SRL:  return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
				F3_OR:   return a | b;
				default: return a & b;
			endcase
		endfunction

		function void note(logic op, logic [31:0] ins, logic [16:0] pa, logic [7:0] pb);
			exec_result_t r;
			logic [6:0]  opc;
			logic [6:0]  f7;
			logic [2:0]  f3;
			logic [4:0]  rd;
			logic [4:0]  rs1;
			logic [4:0]  rs2;
			logic [31:0] a;
			logic [31:0] b;
			logic [31:0] immi;
			logic [31:0] imms;
			logic [31:0] immb;
			logic [31:0] immj;
			logic [31:0] addr;
			logic [31:0] val;
			logic [31:0] lw;
			bit          wr;
			bit          taken;
			int          nbytes;

			r = '0;
			r.inst_addr = pc;
			r.status = ST_EXEC;
			r.next_pc = pc + 32'd4;
			if (op == OP_PRELOAD) begin
				wr_byte({15'd0, pa}, pb);
				r.status = ST_PRELOAD;
				r.next_pc = pc;
				pending.push_back(r);
				return;
			end
			opc = ins[6:0];
			rd = ins[11:7];
			f3 = ins[14:12];
			rs1 = ins[19:15];
			rs2 = ins[24:20];
			f7 = ins[31:25];
			a = xreg(rs1);
			b = xreg(rs2);
			immi = {{20{ins[31]}}, ins[31:20]};
			imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
			immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
			immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
			wr = 0;
			taken = 0;
			val = '0;
			case (opc)
				OPC_OP: begin
					if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL))) begin
						val = alu(f3, f7 == F7_ALT, a, b);
						wr = 1;
					end else r.status = ST_UNKNOWN;
				end
				OPC_OPIMM: begin
					if (f3 == F3_SLL) begin
						if (f7 == F7_BASE) begin
							val = a << rs2;
							wr = 1;
						end else r.status = ST_UNKNOWN;
					end else if (f3 == F3_SRL) begin
						if (f7 == F7_BASE || f7 == F7_ALT) begin
							val = alu(F3_SRL, f7 == F7_ALT, a, {27'd0, rs2});
							wr = 1;
						end else r.status = ST_UNKNOWN;
					end else begin
						val = alu(f3, 0, a, immi);
						wr = 1;
					end
				end
				OPC_LOAD: begin
					addr = a + immi;
					lw = {rd_byte(addr + 32'd3), rd_byte(addr + 32'd2),
						rd_byte(addr + 32'd1), rd_byte(addr)};
					wr = 1;
					case (f3)
						F3_B:    val = {{24{lw[7]}}, lw[7:0]};
						F3_H:    val = {{16{lw[15]}}, lw[15:0]};
						F3_W:    val = lw;
						F3_BU:   val = {24'd0, lw[7:0]};
						F3_HU:   val = {16'd0, lw[15:0]};
						default: begin
							wr = 0;
							r.status = ST_UNKNOWN;
						end
					endcase
				end
				OPC_STORE: begin
					addr = a + imms;
					if (f3 == F3_B || f3 == F3_H || f3 == F3_W) begin
						nbytes = (f3 == F3_B) ? 1 : ((f3 == F3_H) ? 2 : 4);
						for (int i = 0; i < nbytes; i++)
							wr_byte(addr + i, b[8*i +: 8]);
					end else r.status = ST_UNKNOWN;
				end
				OPC_BRANCH: begin
					case (f3)
						F3_BEQ:  taken = (a == b);
						F3_BNE:  taken = (a != b);
						F3_BLT:  taken = ($signed(a) < $signed(b));
						F3_BGE:  taken = ($signed(a) >= $signed(b));
						F3_BLTU: taken = (a < b);
						F3_BGEU: taken = (a >= b);
						default: r.status = ST_UNKNOWN;
					endcase
					if (taken) r.next_pc = pc + immb;
				end
				OPC_JAL: begin
					val = pc + 32'd4;
					wr = 1;
					r.next_pc = pc + immj;
				end
				default: r.status = ST_UNKNOWN;
			endcase
			if (r.status != ST_EXEC || rd == 5'd0) wr = 0;
			if (wr) begin
				regs[rd] = val;
				r.reg_write = 1'b1;
				r.dest_reg = rd;
				r.dest_value = val;
			end
			pc = r.next_pc;
			pending.push_back(r);
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
		endtask

		task check(exec_result_t got);
			exec_result_t want;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected result beat", got.inst_addr, '0);
				return;
			end
			want = pending.pop_front();
			if (got.inst_addr !== want.inst_addr) report("inst_addr", got.inst_addr, want.inst_addr);
			if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
			if (got.reg_write !== want.reg_write)
				report("reg_write", 32'(got.reg_write), 32'(want.reg_write));
			if (got.dest_reg !== want.dest_reg)
				report("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
			if (got.dest_value !== want.dest_value)
				report("dest_value", got.dest_value, want.dest_value);
			if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
		endtask
	endclass

	logic clk;
	logic arst_n;

	rvex_req_if req();
	rvex_rsp_if rsp();

	rv32i_execute_unit_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	exec_scoreboard sb;
	int beats_in;
	int beats_out;
	int idle_cycles;
	int preloads_sent;
	int loads_sent;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Instruction encoders; immediates are given as plain sign-extended values.
	function logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OPC_OP};
	endfunction

	function logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
		logic [4:0] rd, logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
	endfunction

	function logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	function logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
	endfunction

	// The sender waits a random gap, possibly none, before each beat, except in every
	// third block of 100 beats, where it streams back to back.
	task send(logic op, logic [31:0] ins, logic [16:0] pa, logic [7:0] pb);
		int gap;
		gap = ((beats_in / 100) % 3 == 1) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.op <= op;
		req.instr <= ins;
		req.preload_addr <= pa;
		req.preload_byte <= pb;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		sb.note(op, ins, pa, pb);
		beats_in++;
		if (op == OP_PRELOAD) preloads_sent++;
	endtask

	task send_instr(logic [31:0] ins);
		send(OP_EXEC, ins, 17'($urandom), 8'($urandom));
	endtask

	// Memory is only read once written: before a load, every byte it touches
	// that holds no data yet gets a preload beat with a random value.
	task send_load(logic [2:0] f3, logic [4:0] rd, logic [4:0] rs1, logic [11:0] imm);
		logic [31:0] addr;
		logic [16:0] slot;
		int nbytes;
		addr = sb.xreg(rs1) + {{20{imm[11]}}, imm};
		case (f3)
			F3_B, F3_BU: nbytes = 1;
			F3_H, F3_HU: nbytes = 2;
			F3_W:        nbytes = 4;
			default:     nbytes = 0;
		endcase
		for (int i = 0; i < nbytes; i++) begin
			slot = 17'((addr + i) % MEM_SIZE);
			if (!sb.written[slot]) send(OP_PRELOAD, $urandom, slot, 8'($urandom));
		end
		send_instr(enc_i(imm, rs1, f3, rd, OPC_LOAD));
		loads_sent++;
	endtask

	function logic [6:0] pick_f7();
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 1) ? F7_ALT : F7_BASE;
		return 7'($urandom);
	endfunction

	function logic [4:0] pick_rd();
		return ($urandom_range(0, 15) == 0) ? 5'd0 : 5'($urandom);
	endfunction

	task send_random();
		int kind;
		logic [6:0] opc;
		kind = $urandom_range(0, 99);
		if (kind < 20)
			send_instr(enc_r(pick_f7(), 5'($urandom), 5'($urandom), 3'($urandom), pick_rd()));
		else if (kind < 38)
			send_instr(enc_i($urandom_range(0, 2) == 0 ? {pick_f7(), 5'($urandom)} : 12'($urandom),
				5'($urandom), 3'($urandom), pick_rd(), OPC_OPIMM));
		else if (kind < 55)
			send_load(3'($urandom), pick_rd(), 5'($urandom), 12'($urandom));
		else if (kind < 67)
			send_instr(enc_s(12'($urandom), 5'($urandom), 5'($urandom), 3'($urandom)));
		else if (kind < 80)
			send_instr(enc_b(13'($urandom), 5'($urandom), 5'($urandom), 3'($urandom)));
		else if (kind < 85)
			send_instr(enc_j(21'($urandom), pick_rd()));
		else if (kind < 92)
			send(OP_PRELOAD, $urandom, 17'($urandom), 8'($urandom));
		else begin
			// Any opcode the core does not implement, with random remaining bits.
			do opc = 7'($urandom);
			while (opc == OPC_OP || opc == OPC_OPIMM || opc == OPC_LOAD || opc == OPC_STORE ||
				opc == OPC_BRANCH || opc == OPC_JAL);
			send_instr({25'($urandom), opc});
		end
	endtask

	// Result side: random stalls, stall-free stretches, and one long hold-off
	// that lets the core fill its output register and push back on requests.
	initial begin
		int stall;
		exec_result_t got;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ((beats_out / 100) % 4 == 2) ? 0 : $urandom_range(0, 14);
			if (beats_out == 300) stall = 400;
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			got.inst_addr = rsp.inst_addr;
			got.status = status_t'(rsp.status);
			got.reg_write = rsp.reg_write;
			got.dest_reg = rsp.dest_reg;
			got.dest_value = rsp.dest_value;
			got.next_pc = rsp.next_pc;
			sb.check(got);
			beats_out++;
		end
	end

	// Watchdog: any beat on either channel restarts the count.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		sb = new();
		beats_in = 0;
		beats_out = 0;
		idle_cycles = 0;
		preloads_sent = 0;
		loads_sent = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = OP_EXEC;
		req.instr = '0;
		req.preload_addr = '0;
		req.preload_byte = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: immediate extremes, every ALU operation with signed
		// and unsigned corner values, loads and stores that wrap around the end
		// of memory, all six branches, a backward jump and the unknown forms.
		send_instr(enc_i(12'h800, 5'd0, F3_ADD, 5'd1, OPC_OPIMM));
		send_instr(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd2, OPC_OPIMM));
		send_instr(enc_r(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd3));
		send_instr(enc_i({F7_BASE, 5'd31}, 5'd2, F3_SLL, 5'd4, OPC_OPIMM));
		send_instr(enc_i({F7_ALT, 5'd31}, 5'd4, F3_SRL, 5'd5, OPC_OPIMM));
		send_instr(enc_r(F7_BASE, 5'd2, 5'd4, F3_SRL, 5'd6));
		send_instr(enc_r(F7_ALT, 5'd6, 5'd1, F3_SRL, 5'd7));
		send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd8));
		send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_SLTU, 5'd9));
		send_instr(enc_i(12'hFFF, 5'd1, F3_XOR, 5'd10, OPC_OPIMM));
		send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_OR, 5'd11));
		send_instr(enc_r(F7_BASE, 5'd5, 5'd2, F3_AND, 5'd12));
		send(OP_PRELOAD, '0, 17'd0, 8'hFF);
		send(OP_PRELOAD, '0, 17'h1FFFF, 8'h00);
		send_instr(enc_s(12'hFFF, 5'd4, 5'd0, F3_W));
		send_load(F3_W, 5'd13, 5'd0, 12'hFFF);
		send_load(F3_B, 5'd14, 5'd0, 12'h002);
		send_load(F3_HU, 5'd15, 5'd0, 12'h001);
		send_instr(enc_s(12'h7FF, 5'd1, 5'd0, F3_H));
		send_load(F3_H, 5'd16, 5'd0, 12'h7FF);
		send_instr(enc_s(12'h004, 5'd5, 5'd0, F3_B));
		send_load(F3_BU, 5'd17, 5'd0, 12'h004);
		send_instr(enc_b(13'd8, 5'd0, 5'd0, F3_BEQ));
		send_instr(enc_b(13'h1FFC, 5'd2, 5'd1, F3_BNE));
		send_instr(enc_b(13'h1000, 5'd2, 5'd1, F3_BLT));
		send_instr(enc_b(13'h0FFE, 5'd2, 5'd1, F3_BGE));
		send_instr(enc_b(13'd16, 5'd2, 5'd1, F3_BLTU));
		send_instr(enc_b(13'd16, 5'd2, 5'd1, F3_BGEU));
		send_instr(enc_j(21'h1FFFFC, 5'd1));
		send_instr(enc_j(21'h0FFFFE, 5'd0));
		send_instr({25'd0, 7'h7F});
		send_instr(enc_r(7'h01, 5'd2, 5'd1, F3_ADD, 5'd18));
		send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0));

		for (int n = 0; n < NUM_RANDOM; n++) send_random();
		req.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d request beats (%0d preloads, %0d loads) and checked %0d results.",
			beats_in, preloads_sent, loads_sent, sb.checked);
		$display("Mismatches found: %0d", sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rvex_pkg.sv
rtl/core/rvex_if.sv
rtl/core/rvex_ram.sv
rtl/core/rvex_alu.sv
rtl/core/rv32i_execute_unit_core.sv
sim/rv32i_execute_unit_core_tb.sv
